>>> sv/clt_pkg.sv
// Shared types and constants of the command line number tokenizer.
// Used by clt_parse and command_line_number_tokenizer; depends on nothing.
`default_nettype none

package clt_pkg;

   localparam logic KIND_PARAM   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_HIGH      = 8'h80;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
   localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
   localparam logic [7:0] CHAR_CASE_DIFF = 8'h20;
   localparam logic [3:0] HEX_LETTER_ADJ = 4'd9;

   // Results caused by one request: an optional parameter, then an optional summary.
   typedef struct packed {
      logic        has_param;
      logic [31:0] value;
      logic        is_unsigned;
      logic [1:0]  slot;
      logic        has_summary;
      logic [7:0]  total;
   } item_type;

endpackage

`default_nettype wire

>>> sv/command_line_number_tokenizer.sv
// Top level of the command line number tokenizer: request register, parser, result queue.
// Depends on clt_pkg and clt_parse.
//
//   Channel   Handshake              Fields
//   request   req_valid, req_stall   req_char_code, req_end_of_line
//   response  rsp_valid, rsp_stall   rsp_result_kind to rsp_last_of_run, six ports
//
// One request is taken per cycle unless req_stall is high; responses leave the result queue.
// A request that closes a word with a parameter and ends the line gives two responses
// from one queue entry; the two-entry queue gives one response per cycle unless rsp_stall.
// Reset clears the word state, the counters, the request valid flag and the result queue.
// A stalled response holds the queue; the request side stalls once the queue is full.
`default_nettype none

module command_line_number_tokenizer #(
   parameter int MAX_PARAMS       = 4,
   parameter int WORD_COUNT_LIMIT = 32,
   parameter int VALUE_WIDTH      = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_end_of_line,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_result_kind,
   output logic [31:0]      rsp_param_value,
   output logic             rsp_param_is_unsigned,
   output logic [1:0]       rsp_param_slot,
   output logic [7:0]       rsp_word_total,
   output logic             rsp_last_of_run
);

   localparam int QUEUE_DEPTH = 2;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_char_ff;
   logic                  in_eol_ff;
   logic                  fire;
   logic                  push;
   logic                  pop;
   logic                  deliver;
   logic                  show_sum;
   clt_pkg::item_type     item;
   clt_pkg::item_type     head;
   clt_pkg::item_type     queue_ff [QUEUE_DEPTH];
   logic                  wr_ptr_ff, rd_ptr_ff;
   logic [1:0]            count_ff, count_in;
   logic                  phase_ff, phase_in;

   assign fire        = in_valid_ff && (count_ff != 2'(QUEUE_DEPTH));
   assign req_stall   = in_valid_ff && !fire;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !fire);

   clt_parse #(
      .MAX_PARAMS       (MAX_PARAMS),
      .WORD_COUNT_LIMIT (WORD_COUNT_LIMIT),
      .VALUE_WIDTH      (VALUE_WIDTH)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .enable      (fire),
      .char_code   (in_char_ff),
      .end_of_line (in_eol_ff),
      .item        (item)
   );

   assign push      = fire && (item.has_param || item.has_summary);
   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != 2'd0);
   assign show_sum  = !head.has_param || phase_ff;
   assign deliver   = rsp_valid && !rsp_stall;
   assign pop       = deliver && rsp_last_of_run;

   always_comb begin
      rsp_result_kind       = show_sum ? clt_pkg::KIND_SUMMARY : clt_pkg::KIND_PARAM;
      rsp_param_value       = show_sum ? 32'd0 : head.value;
      rsp_param_is_unsigned = show_sum ? 1'b0 : head.is_unsigned;
      rsp_param_slot        = show_sum ? 2'd0 : head.slot;
      rsp_word_total        = show_sum ? head.total : 8'd0;
      rsp_last_of_run       = show_sum || !head.has_summary;
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
      phase_in = phase_ff;
      if (deliver) begin
         phase_in = !rsp_last_of_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         count_ff    <= 2'd0;
         phase_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
         phase_ff    <= phase_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_code;
         in_eol_ff  <= req_end_of_line;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("result queue count exceeds its depth");

   a_phase_pair: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (rsp_valid && head.has_param && head.has_summary))
      else $error("second response phase without a paired entry");

   a_summary_follows: assert property (@(posedge clock) disable iff (reset)
      (deliver && !rsp_last_of_run)
      |=> (rsp_valid && rsp_result_kind == clt_pkg::KIND_SUMMARY))
      else $error("summary did not follow a non-final parameter response");

endmodule

`default_nettype wire

>>> sv/clt_parse.sv
// Word splitter and dual decimal/hex number parser, one byte per enable.
// Depends on clt_pkg for character constants and the item_type result bundle.
`default_nettype none

module clt_parse #(
   parameter int MAX_PARAMS       = 4,
   parameter int WORD_COUNT_LIMIT = 32,
   parameter int VALUE_WIDTH      = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic [7:0]        char_code,
   input  wire logic              end_of_line,
   output clt_pkg::item_type      item
);

   localparam int CW = $clog2(WORD_COUNT_LIMIT + 1);
   localparam int TW = $clog2(MAX_PARAMS + 1);
   localparam int VW = VALUE_WIDTH;

   logic [VW-1:0] dec_ff, dec_in;
   logic [VW-1:0] hex_ff, hex_in;
   logic [CW-1:0] count_ff, count_in;
   logic          not_dec_ff, not_dec_in;
   logic          not_hex_ff, not_hex_in;
   logic          minus_ff, minus_in;
   logic          zero_ff, zero_in;
   logic [7:0]    words_ff, words_in;
   logic [TW-1:0] taken_ff, taken_in;

   logic          is_word;
   logic [7:0]    upper;
   logic          is_dig;
   logic          is_hex;
   logic [3:0]    nibble;
   logic [VW-1:0] dec_next;
   logic [VW-1:0] hex_next;
   logic [VW-1:0] signed_val;
   logic [VW+31:0] dec_wide;
   logic [VW+31:0] hex_wide;
   logic [TW+1:0] slot_wide;

   assign is_word  = (char_code > clt_pkg::CHAR_SPACE) && (char_code < clt_pkg::CHAR_HIGH);
   assign upper    = ((char_code >= clt_pkg::CHAR_LOWER_A) && (char_code <= clt_pkg::CHAR_LOWER_Z))
                     ? char_code - clt_pkg::CHAR_CASE_DIFF : char_code;
   assign is_dig   = (upper >= clt_pkg::CHAR_ZERO) && (upper <= clt_pkg::CHAR_NINE);
   assign is_hex   = is_dig || ((upper >= clt_pkg::CHAR_UPPER_A) && (upper <= clt_pkg::CHAR_UPPER_F));
   assign nibble   = is_dig ? upper[3:0] : upper[3:0] + clt_pkg::HEX_LETTER_ADJ;
   assign dec_next = (dec_ff << 3) + (dec_ff << 1) + VW'(nibble);
   assign hex_next = (hex_ff << 4) | VW'(nibble);

   assign signed_val = minus_ff ? (~dec_ff + VW'(1)) : dec_ff;
   assign dec_wide   = {32'b0, signed_val};
   assign hex_wide   = {32'b0, hex_ff};
   assign slot_wide  = {2'b0, taken_ff};

   always_comb begin
      dec_in     = dec_ff;
      hex_in     = hex_ff;
      count_in   = count_ff;
      not_dec_in = not_dec_ff;
      not_hex_in = not_hex_ff;
      minus_in   = minus_ff;
      zero_in    = zero_ff;
      words_in   = words_ff;
      taken_in   = taken_ff;
      item       = '0;

      if (is_word) begin
         if (count_ff == '0) begin
            words_in = words_ff + 8'd1;
         end
         if (count_ff < CW'(WORD_COUNT_LIMIT)) begin
            if (count_ff == '0) begin
               zero_in = (char_code == clt_pkg::CHAR_ZERO);
            end
            count_in = count_ff + CW'(1);
         end
         if ((upper == clt_pkg::CHAR_MINUS) && (count_in == CW'(1))) begin
            minus_in   = 1'b1;
            not_hex_in = 1'b1;
         end else if (!not_dec_ff && is_dig) begin
            dec_in = dec_next;
            if (!not_hex_ff) begin
               hex_in = hex_next;
            end
         end else if (!not_hex_ff && is_hex) begin
            not_dec_in = 1'b1;
            hex_in     = hex_next;
         end else if (!not_hex_ff && zero_in && (upper == clt_pkg::CHAR_UPPER_X)
                      && (count_in == CW'(2))) begin
            not_dec_in = 1'b1;
         end else begin
            not_dec_in = 1'b1;
            not_hex_in = 1'b1;
         end
      end else if (count_ff != '0) begin
         if ((taken_ff < TW'(MAX_PARAMS)) && (!not_dec_ff || !not_hex_ff)) begin
            item.has_param   = 1'b1;
            item.is_unsigned = not_dec_ff;
            item.value       = not_dec_ff ? hex_wide[31:0] : dec_wide[31:0];
            item.slot        = slot_wide[1:0];
            taken_in         = taken_ff + TW'(1);
         end
         dec_in     = '0;
         hex_in     = '0;
         count_in   = '0;
         not_dec_in = 1'b0;
         not_hex_in = 1'b0;
         minus_in   = 1'b0;
         zero_in    = 1'b0;
      end

      if (end_of_line) begin
         item.has_summary = 1'b1;
         item.total       = words_in;
         dec_in           = '0;
         hex_in           = '0;
         count_in         = '0;
         not_dec_in       = 1'b0;
         not_hex_in       = 1'b0;
         minus_in         = 1'b0;
         zero_in          = 1'b0;
         words_in         = '0;
         taken_in         = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff     <= '0;
         hex_ff     <= '0;
         count_ff   <= '0;
         not_dec_ff <= 1'b0;
         not_hex_ff <= 1'b0;
         minus_ff   <= 1'b0;
         zero_ff    <= 1'b0;
         words_ff   <= '0;
         taken_ff   <= '0;
      end else if (enable) begin
         dec_ff     <= dec_in;
         hex_ff     <= hex_in;
         count_ff   <= count_in;
         not_dec_ff <= not_dec_in;
         not_hex_ff <= not_hex_in;
         minus_ff   <= minus_in;
         zero_ff    <= zero_in;
         words_ff   <= words_in;
         taken_ff   <= taken_in;
      end
   end

endmodule

`default_nettype wire
